// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, muted while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds, muted while reset is held.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/mjdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mjdc_pkg;

  localparam int MJD_W   = 16;
  localparam int N_W     = 20;  // 20*mjd - 301564 for valid dates
  localparam int YR_W    = 8;   // years since 1900, before the March carry
  localparam int X_W     = 9;   // day count from the March-based year start
  localparam int NUM_W   = 23;  // 10000*X - 1000
  localparam int M_W     = 4;
  localparam int YEAR_W  = 11;
  localparam int DAY_W   = 5;

  localparam logic [MJD_W-1:0] MJD_MIN_VALID = 16'd15079;

  // floor(n/7305) = (n * Y_RECIP) >> Y_SHIFT, exact for n below 2^20
  localparam int            Y_RECIP_W = 21;
  localparam logic [20:0]   Y_RECIP   = 21'd1175898;
  localparam int            Y_SHIFT   = 33;

  // floor(n/306001) = (n * M_RECIP) >> M_SHIFT, exact for n below 7360000,
  // which covers the largest numerator a valid date gives (10000*488 - 1000)
  localparam int            M_RECIP_W = 22;
  localparam logic [21:0]   M_RECIP   = 22'd3593164;
  localparam int            M_SHIFT   = 40;

  localparam logic [M_W-1:0] M_JAN = 4'd14;
  localparam logic [M_W-1:0] M_FEB = 4'd15;

  // floor(30.6001 * m) for the month codes the formula produces
  function automatic logic [X_W-1:0] month_base(input logic [M_W-1:0] m);
    logic [X_W-1:0] b;
    case (m)
      4'd4:    b = 9'd122;
      4'd5:    b = 9'd153;
      4'd6:    b = 9'd183;
      4'd7:    b = 9'd214;
      4'd8:    b = 9'd244;
      4'd9:    b = 9'd275;
      4'd10:   b = 9'd306;
      4'd11:   b = 9'd336;
      4'd12:   b = 9'd367;
      4'd13:   b = 9'd397;
      4'd14:   b = 9'd428;
      4'd15:   b = 9'd459;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mjd_to_calendar_date.sv =====
// Channel   Dir  Handshake                       Payload (lowest bit first)
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata[15:0] mjd
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: year, month, day, date_valid
//
// Six register stages; one date enters per cycle unless m_axis stalls and
// all six are full. Depth is set by the two reciprocal multiplies (divide
// by 7305 and 306001), each with its own stage, plus the year-day multiply.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds while the one after it is full and stalled, so a stall
// on m_axis backs up stage by stage and s_axis_tready drops only once all
// six stages are full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mjd_to_calendar_date (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] mjd
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata    // [10:0] year, [14:11] month,
                                           // [19:15] day, [20] date_valid, rest 0
);

  // stage valid bits and per-stage advance enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  // stage 1: range check and numerator for the year quotient
  logic [mjdc_pkg::MJD_W-1:0]  mjd1_q;
  logic                        ok1_q;
  logic [mjdc_pkg::N_W-1:0]    n1_q;
  // stage 2: years since 1900 (March based)
  logic [mjdc_pkg::MJD_W-1:0]  mjd2_q;
  logic                        ok2_q;
  logic [mjdc_pkg::YR_W-1:0]   y2_q;
  // stage 3: day of the March-based year
  logic                        ok3_q;
  logic [mjdc_pkg::YR_W-1:0]   y3_q;
  logic [mjdc_pkg::X_W-1:0]    x3_q;
  // stage 4: numerator for the month quotient
  logic                        ok4_q;
  logic [mjdc_pkg::YR_W-1:0]   y4_q;
  logic [mjdc_pkg::X_W-1:0]    x4_q;
  logic [mjdc_pkg::NUM_W-1:0]  num4_q;
  // stage 5: month code 4..15
  logic                        ok5_q;
  logic [mjdc_pkg::YR_W-1:0]   y5_q;
  logic [mjdc_pkg::X_W-1:0]    x5_q;
  logic [mjdc_pkg::M_W-1:0]    m5_q;
  // stage 6: output register
  logic [mjdc_pkg::YEAR_W-1:0] year6_q;
  logic [mjdc_pkg::M_W-1:0]    month6_q;
  logic [mjdc_pkg::DAY_W-1:0]  day6_q;
  logic                        dv6_q;

  // next values
  logic [mjdc_pkg::N_W:0]      n_full;
  logic [mjdc_pkg::N_W-1:0]    n1_d;
  logic [mjdc_pkg::N_W+mjdc_pkg::Y_RECIP_W-1:0] prod_y;
  logic [mjdc_pkg::YR_W-1:0]   y2_d;
  logic [18:0]                 yd_full;
  logic [16:0]                 x_full;
  logic [mjdc_pkg::X_W-1:0]    x3_d;
  logic [mjdc_pkg::NUM_W-1:0]  num4_d;
  logic [mjdc_pkg::NUM_W+mjdc_pkg::M_RECIP_W-1:0] prod_m;
  logic [mjdc_pkg::M_W-1:0]    m5_d;
  logic                        carry;
  logic [mjdc_pkg::X_W-1:0]    day_full;
  logic [mjdc_pkg::YEAR_W-1:0] year6_d;
  logic [mjdc_pkg::M_W-1:0]    month6_d;
  logic [mjdc_pkg::DAY_W-1:0]  day6_d;

  // a stage advances when it is empty or its successor advances
  assign en6 = !v6_q || m_axis_tready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_comb begin
    // 20*mjd - 301564, wraps for early dates which are masked at the end
    n_full = (21'(s_axis_tdata) * 21'd20) - 21'd301564;
    n1_d   = n_full[mjdc_pkg::N_W-1:0];

    prod_y = (mjdc_pkg::N_W + mjdc_pkg::Y_RECIP_W)'(n1_q)
           * (mjdc_pkg::N_W + mjdc_pkg::Y_RECIP_W)'(mjdc_pkg::Y_RECIP);
    y2_d   = prod_y[mjdc_pkg::Y_SHIFT +: mjdc_pkg::YR_W];

    // floor(1461*y/4) is the day count of the whole years
    yd_full = 19'(y2_q) * 19'd1461;
    x_full  = 17'(mjd2_q) - 17'd14956 - yd_full[18:2];
    x3_d    = x_full[mjdc_pkg::X_W-1:0];

    num4_d = (23'(x3_q) * 23'd10000) - 23'd1000;

    prod_m = (mjdc_pkg::NUM_W + mjdc_pkg::M_RECIP_W)'(num4_q)
           * (mjdc_pkg::NUM_W + mjdc_pkg::M_RECIP_W)'(mjdc_pkg::M_RECIP);
    m5_d   = prod_m[mjdc_pkg::M_SHIFT +: mjdc_pkg::M_W];

    // January and February belong to the next calendar year
    carry    = (m5_q == mjdc_pkg::M_JAN) || (m5_q == mjdc_pkg::M_FEB);
    day_full = x5_q - mjdc_pkg::month_base(m5_q);
    if (ok5_q) begin
      year6_d  = 11'(y5_q) + 11'(carry) + 11'd1900;
      month6_d = m5_q - 4'd1 - (carry ? 4'd12 : 4'd0);
      day6_d   = day_full[mjdc_pkg::DAY_W-1:0];
    end else begin
      year6_d  = '0;
      month6_d = '0;
      day6_d   = '0;
    end
  end

  // valid bits: the only state reset has to clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // payload: load only on a transfer into the stage, hold otherwise
  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      mjd1_q <= s_axis_tdata;
      ok1_q  <= (s_axis_tdata >= mjdc_pkg::MJD_MIN_VALID);
      n1_q   <= n1_d;
    end
    if (en2 && v1_q) begin
      mjd2_q <= mjd1_q;
      ok2_q  <= ok1_q;
      y2_q   <= y2_d;
    end
    if (en3 && v2_q) begin
      ok3_q <= ok2_q;
      y3_q  <= y2_q;
      x3_q  <= x3_d;
    end
    if (en4 && v3_q) begin
      ok4_q  <= ok3_q;
      y4_q   <= y3_q;
      x4_q   <= x3_q;
      num4_q <= num4_d;
    end
    if (en5 && v4_q) begin
      ok5_q <= ok4_q;
      y5_q  <= y4_q;
      x5_q  <= x4_q;
      m5_q  <= m5_d;
    end
    if (en6 && v5_q) begin
      year6_q  <= year6_d;
      month6_q <= month6_d;
      day6_q   <= day6_d;
      dv6_q    <= ok5_q;
    end
  end

  assign m_axis_tvalid = v6_q;
  assign m_axis_tdata  = {3'b000, dv6_q, day6_q, month6_q, year6_q};

  // input stalls only when every stage holds an item
  `ASSERT_CLK(a_full_on_stall, clk_i, rst_ni,
    !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q && v5_q && v6_q),
    "input stalled with an empty stage")
  // a stalled stage five keeps its month code
  `ASSERT_CLK(a_hold_stage5, clk_i, rst_ni,
    (v5_q && !en5) |=> (v5_q && $stable(m5_q) && $stable(x5_q)),
    "stage five changed while stalled")
  // a valid date always carries a real month and day
  `ASSERT_CLK(a_date_range, clk_i, rst_ni,
    (v6_q && dv6_q) |-> (month6_q >= 4'd1 && month6_q <= 4'd12 && day6_q != 5'd0
                         && year6_q >= 11'd1900 && year6_q <= 11'd2038),
    "valid date out of range")
  // an invalid date shows zero fields
  `ASSERT_NEVER(a_zero_invalid, clk_i, rst_ni,
    v6_q && !dv6_q && (year6_q != '0 || month6_q != '0 || day6_q != '0),
    "invalid date with nonzero fields")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  localparam logic [15:0] MJD_MIN_VALID = mjdc_pkg::MJD_MIN_VALID;
  localparam logic [3:0]  M_JAN         = mjdc_pkg::M_JAN;
  localparam logic [3:0]  M_FEB         = mjdc_pkg::M_FEB;
  localparam int          YEAR_W        = mjdc_pkg::YEAR_W;
  localparam int          M_W           = mjdc_pkg::M_W;
  localparam int          DAY_W         = mjdc_pkg::DAY_W;

  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES    = 20;

  // Layout of m_axis_tdata, highest field first
  typedef struct packed {
    logic [2:0]        pad;
    logic              valid;
    logic [DAY_W-1:0]  day;
    logic [M_W-1:0]    month;
    logic [YEAR_W-1:0] year;
  } cal_date_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  cal_date_t   pending_dates[$];
  int unsigned n_sent, n_checked, n_early, n_jan_feb, n_errors;
  int unsigned burst_left;
  int unsigned quiet_cycles = 0;
  bit          no_gaps;
  bit          hold_off_req;

  mjd_to_calendar_date DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every intermediate is non-negative once the date is in range, so plain
  // integer division gives the floor that the rational steps need.
  function automatic cal_date_t mjd_to_date(input logic [15:0] mjd);
    cal_date_t r;
    longint    day_num, yrs, year_days, x, m, carry;
    r = '0;
    if (mjd >= MJD_MIN_VALID) begin
      day_num   = longint'(mjd);
      yrs       = (20 * day_num - 301564) / 7305;
      year_days = (1461 * yrs) / 4;
      x         = day_num - 14956 - year_days;
      m         = (10000 * x - 1000) / 306001;
      carry     = (m == M_JAN || m == M_FEB) ? 1 : 0;
      r.day     = DAY_W'(x - (306001 * m) / 10000);
      r.year    = YEAR_W'(yrs + carry + 1900);
      r.month   = M_W'(m - 1 - 12 * carry);
      r.valid   = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [15:0] random_mjd();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70)      return 16'($urandom_range(MJD_MIN_VALID, 65535));
    else if (sel < 80) return 16'($urandom_range(0, MJD_MIN_VALID - 1));
    else if (sel < 88) return 16'($urandom_range(MJD_MIN_VALID - 4, MJD_MIN_VALID + 4));
    else               return 16'($urandom);
  endfunction

  // Offer one date, wait for the transfer, then maybe drop valid for a gap
  task automatic send_date(input logic [15:0] mjd);
    s_axis_tdata  <= mjd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_dates.push_back(mjd_to_date(mjd));
    n_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !no_gaps) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 48);
    end
  endtask

  function automatic void report_field(input string name, input int want, input int got);
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    n_errors++;
  endfunction

  // Check every result transfer against the oldest expected date
  always @(posedge clk_i) begin
    cal_date_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        n_errors++;
      end else begin
        want = pending_dates.pop_front();
        n_checked++;
        if (!want.valid) n_early++;
        if (want.valid && want.month <= 2) n_jan_feb++;
        if (got.year  !== want.year)  report_field("year", want.year, got.year);
        if (got.month !== want.month) report_field("month", want.month, got.month);
        if (got.day   !== want.day)   report_field("day", want.day, got.day);
        if (got.valid !== want.valid) report_field("date_valid", want.valid, got.valid);
        if (got.pad   !== want.pad)   report_field("pad bits", want.pad, got.pad);
      end
    end
  end

  // Receiver: ready rate changes from phase to phase; a requested hold-off
  // keeps ready low for a long stretch.
  initial begin : sink_stalls
    int unsigned hold_left, phase_left, ready_pct;
    hold_left  = 0;
    phase_left = 0;
    ready_pct  = 100;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(20, 300);
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 80;
            2:       ready_pct = 50;
            default: ready_pct = 15;
          endcase
        end
        phase_left--;
        m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, pending_dates.size());
    $display("Mismatches found");
    $finish;
  end

  task automatic test_directed_dates();
    logic [15:0] dates[$];
    // zero, early dates, first valid day, year and leap-day edges, bit
    // patterns and the top of the field
    dates = '{16'd0, 16'd1, 16'd15020, 16'd15078, 16'd15079, 16'd15080,
              16'd15384, 16'd15385, 16'd16539, 16'd16540, 16'd51543, 16'd51544,
              16'd51603, 16'd51604, 16'h7FFF, 16'h8000, 16'hAAAA, 16'h5555,
              16'd65423, 16'd65424, 16'd65534, 16'hFFFF};
    foreach (dates[i]) send_date(dates[i]);
  endtask

  task automatic test_random_dates();
    repeat (1600) send_date(random_mjd());
  endtask

  // Stall the output long enough to fill the pipeline and back up s_axis
  task automatic test_output_backpressure();
    no_gaps      = 1'b1;
    hold_off_req = 1'b1;
    repeat (40) send_date(16'($urandom_range(MJD_MIN_VALID, 65535)));
    no_gaps = 1'b0;
    repeat (260) send_date(random_mjd());
  endtask

  initial begin
    n_sent       = 0;
    n_checked    = 0;
    n_early      = 0;
    n_jan_feb    = 0;
    n_errors     = 0;
    burst_left   = 0;
    no_gaps      = 1'b0;
    hold_off_req = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_dates();
    test_random_dates();
    test_output_backpressure();

    s_axis_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d dates: %0d before the valid range, %0d in January or February.",
             n_checked, n_early, n_jan_feb);
    $display("Output held off once for %0d cycles; %0d field mismatches.",
             HOLD_OFF_CYCLES, n_errors);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
